// ----- hdl/itoa_pkg.sv -----
// itoa_pkg: shared types, constants and the digit table for the integer to
// ASCII digit converter. No dependencies.
`default_nettype none
package itoa_pkg;

  // Conversion kinds
  localparam logic [2:0] KIND_HEX64 = 3'd0;
  localparam logic [2:0] KIND_SDEC  = 3'd1;
  localparam logic [2:0] KIND_UDEC  = 3'd2;
  localparam logic [2:0] KIND_HEXL  = 3'd3;
  localparam logic [2:0] KIND_HEXU  = 3'd4;

  localparam int MAX_DIGITS = 16;
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);

  // 2^35 / 10 rounded up: exact quotient for any 32-bit dividend
  localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;

  localparam logic [7:0] DIGIT_CHARS [32] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66,
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };

  // Microprogram addresses; emit sits at the top so its fall-through wraps
  // to the accept step
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_ACCEPT  = 3'd0;
  localparam logic [STEP_W-1:0] STEP_DISPAT  = 3'd1;
  localparam logic [STEP_W-1:0] STEP_MUL     = 3'd2;
  localparam logic [STEP_W-1:0] STEP_REM     = 3'd3;
  localparam logic [STEP_W-1:0] STEP_DECDONE = 3'd4;
  localparam logic [STEP_W-1:0] STEP_HEX     = 3'd6;
  localparam logic [STEP_W-1:0] STEP_EMIT    = 3'd7;

  typedef enum logic [2:0] {
    OP_NOP, OP_ACCEPT, OP_HEX, OP_MUL, OP_REM, OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    C_NEXT, C_ALWAYS, C_NO_TAKE, C_HEX, C_MORE_HEX, C_MORE_DEC, C_NOT_DONE
  } cond_t;

  typedef struct packed {
    op_t               op;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic take;      // request accepted with a known kind
    logic is_hex;
    logic more_hex;
    logic more_dec;
    logic done;      // final character taken
  } stat_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [63:0] value;
  } in_req_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
  } out_req_t;

  function automatic logic [7:0] digit_char(input logic upper, input logic [3:0] d);
    return DIGIT_CHARS[{upper, d}];
  endfunction

endpackage
`default_nettype wire

// ----- hdl/integer_to_ascii_digits_top.sv -----
// integer_to_ascii_digits_top: top level of the integer to ASCII digit
// converter. Depends on itoa_pkg, itoa_useq and itoa_dp.
//
// Usage
// - Input channel (in_valid/in_ready/in_data): one request carries a kind
//   (hex64, signed dec32 magnitude, unsigned dec32, hex32 lower/upper) and a
//   64-bit value. in_ready is high only while the sequencer sits at its
//   accept step; a request of an unknown kind (5..7) is taken and dropped.
// - Output channel (out_valid/out_ready/out_data): one ASCII digit per
//   transfer, most significant first, no leading zeros; zero gives '0'.
//   out_data.last marks the final digit.
// - Sequence: an accept step, a dispatch step, then one hex step per hex
//   digit, or two steps per decimal digit (reciprocal multiply, then
//   remainder) plus one closing step. Digits then leave at one per cycle
//   while out_ready is high.
// - One request at a time: a new request is taken in the cycle after the
//   last digit is delivered.
// - A receiver stall holds out_valid and the current digit steady.
// - Synchronous reset (rst_n low) returns the sequencer to its accept step.
`default_nettype none
module integer_to_ascii_digits_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire itoa_pkg::in_req_t  in_data,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output itoa_pkg::out_req_t      out_data
);
  import itoa_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  // microcode sequencer: step counter plus control ROM
  itoa_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  // datapath: magnitude, divide-by-ten, digit shift register, count
  itoa_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_data  (out_data),
    .stat      (stat)
  );

  // handshakes come straight from the current control word
  assign in_ready  = (ctrl.op == OP_ACCEPT);
  assign out_valid = (ctrl.op == OP_EMIT);

endmodule
`default_nettype wire

// ----- hdl/itoa_useq.sv -----
// itoa_useq: step counter and microprogram ROM with conditional jumps.
// Depends on itoa_pkg.
`default_nettype none
module itoa_useq (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire itoa_pkg::stat_t stat,
  output itoa_pkg::ctrl_t     ctrl
);
  import itoa_pkg::*;

  logic [STEP_W-1:0] pc_r, pc_nxt;
  logic              jump;

  // microprogram
  always_comb begin
    case (pc_r)
      STEP_ACCEPT:  ctrl = '{OP_ACCEPT, C_NO_TAKE,  STEP_ACCEPT};
      STEP_DISPAT:  ctrl = '{OP_NOP,    C_HEX,      STEP_HEX};
      STEP_MUL:     ctrl = '{OP_MUL,    C_NEXT,     STEP_REM};
      STEP_REM:     ctrl = '{OP_REM,    C_MORE_DEC, STEP_MUL};
      STEP_DECDONE: ctrl = '{OP_NOP,    C_ALWAYS,   STEP_EMIT};
      STEP_HEX:     ctrl = '{OP_HEX,    C_MORE_HEX, STEP_HEX};
      STEP_EMIT:    ctrl = '{OP_EMIT,   C_NOT_DONE, STEP_EMIT};
      default:      ctrl = '{OP_NOP,    C_ALWAYS,   STEP_ACCEPT};
    endcase
  end

  always_comb begin
    case (ctrl.cond)
      C_NEXT:     jump = 1'b0;
      C_ALWAYS:   jump = 1'b1;
      C_NO_TAKE:  jump = !stat.take;
      C_HEX:      jump = stat.is_hex;
      C_MORE_HEX: jump = stat.more_hex;
      C_MORE_DEC: jump = stat.more_dec;
      C_NOT_DONE: jump = !stat.done;
      default:    jump = 1'b1;
    endcase
    pc_nxt = jump ? ctrl.target : pc_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= STEP_ACCEPT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/itoa_dp.sv -----
// itoa_dp: magnitude, quotient and digit registers driven by the control word.
// Depends on itoa_pkg.
`default_nettype none
module itoa_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire itoa_pkg::ctrl_t   ctrl,
  input  wire logic              in_valid,
  input  wire itoa_pkg::in_req_t in_data,
  input  wire logic              out_ready,
  output itoa_pkg::out_req_t     out_data,
  output itoa_pkg::stat_t        stat
);
  import itoa_pkg::*;

  logic [63:0]      mag_r, mag_nxt;
  logic [63:0]      digs_r, digs_nxt;   // digits, most significant in top nibble
  logic [28:0]      q_r, q_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic             hex_r, hex_nxt;
  logic             upper_r, upper_nxt;
  logic             kind_ok;
  logic [31:0]      low, neg_low;
  logic [63:0]      prod;
  logic [31:0]      q_x10;
  logic [31:0]      rem_full;

  assign low     = in_data.value[31:0];
  assign neg_low = ~low + 32'd1;
  assign kind_ok = in_data.req_type inside {KIND_HEX64, KIND_SDEC, KIND_UDEC,
                                            KIND_HEXL, KIND_HEXU};
  assign prod     = mag_r[31:0] * RECIP10;
  assign q_x10    = {q_r, 3'b000} + {2'b00, q_r, 1'b0};
  assign rem_full = mag_r[31:0] - q_x10;

  always_comb begin
    mag_nxt   = mag_r;
    digs_nxt  = digs_r;
    q_nxt     = q_r;
    n_nxt     = n_r;
    hex_nxt   = hex_r;
    upper_nxt = upper_r;
    case (ctrl.op)
      OP_ACCEPT: begin
        n_nxt     = '0;
        hex_nxt   = in_data.req_type inside {KIND_HEX64, KIND_HEXL, KIND_HEXU};
        upper_nxt = (in_data.req_type == KIND_HEXU);
        if (in_data.req_type == KIND_HEX64) begin
          mag_nxt = in_data.value;
        end else if (in_data.req_type == KIND_SDEC && low[31]) begin
          mag_nxt = {32'd0, neg_low};
        end else begin
          mag_nxt = {32'd0, low};
        end
      end
      OP_HEX: begin
        digs_nxt = {mag_r[3:0], digs_r[63:4]};
        mag_nxt  = {4'd0, mag_r[63:4]};
        n_nxt    = n_r + 1'b1;
      end
      OP_MUL: begin
        q_nxt = prod[63:35];
      end
      OP_REM: begin
        digs_nxt = {rem_full[3:0], digs_r[63:4]};
        mag_nxt  = {35'd0, q_r};
        n_nxt    = n_r + 1'b1;
      end
      OP_EMIT: begin
        if (out_ready) begin
          digs_nxt = {digs_r[59:0], 4'd0};
          n_nxt    = n_r - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r <= '0;
    end else begin
      n_r <= n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r   <= mag_nxt;
    digs_r  <= digs_nxt;
    q_r     <= q_nxt;
    hex_r   <= hex_nxt;
    upper_r <= upper_nxt;
  end

  assign out_data.char_code = digit_char(upper_r, digs_r[63:60]);
  assign out_data.last      = (n_r == CNT_W'(1));

  assign stat.take     = in_valid && kind_ok;
  assign stat.is_hex   = hex_r;
  assign stat.more_hex = (mag_r[63:4] != 60'd0);
  assign stat.more_dec = (q_r != 29'd0);
  assign stat.done     = out_ready && out_data.last;

endmodule
`default_nettype wire

// ----- hdl/itoa_chk.sv -----
// itoa_chk: port-level checks for integer_to_ascii_digits_top, and its bind.
// Depends on itoa_pkg.
`default_nettype none
module itoa_chk (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire itoa_pkg::in_req_t  in_data,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire itoa_pkg::out_req_t out_data
);
  import itoa_pkg::*;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("digit changed under stall");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("accepting while emitting");

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.last |=> in_ready)
    else $error("not ready after last digit");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.req_type == KIND_HEX64 ||
      in_data.req_type == KIND_SDEC || in_data.req_type == KIND_UDEC ||
      in_data.req_type == KIND_HEXL || in_data.req_type == KIND_HEXU)
    |=> !in_ready)
    else $error("ready while converting");

endmodule

bind integer_to_ascii_digits_top itoa_chk u_itoa_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire
